@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is active
`define SRA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off while reset is active
`define SRA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/sra_pkg.sv @@
package sra_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 12;
    localparam int DIM_BITS     = COORD_BITS + 1;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
    localparam int AREA_BITS    = 25;
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS     = ((PROD_BITS > AREA_BITS) ? PROD_BITS : AREA_BITS) + 1;

    localparam logic [COORD_BITS-1:0] COORD_MAX   = '1;
    localparam logic [AREA_BITS-1:0]  AREA_MAX    = '1;
    localparam logic [DIM_BITS-1:0]   ATLAS_RESET = DIM_BITS'(512);

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic CFG_ATLAS_W = 1'b0;
    localparam logic CFG_ATLAS_H = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
    } seg_t;

    // one fit probe traveling up the chain
    typedef struct packed {
        logic                  active;
        logic                  ok;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] y;
        logic [IDX_BITS-1:0]   idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] w;
    } probe_t;

    // common control to every cell
    typedef struct packed {
        logic                  search_start;
        logic                  search_step;
        logic                  pop;
        logic                  push;
        logic                  load_clear;
        seg_t                  push_seg;
        seg_t                  clear_seg;
        logic [CNT_BITS-1:0]   occ;
        logic [COORD_BITS-1:0] req_w;
        logic [COORD_BITS-1:0] req_h;
        logic [DIM_BITS-1:0]   atlas_w;
        logic [DIM_BITS-1:0]   atlas_h;
    } cell_ctl_t;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [DIM_BITS-1:0] v);
        logic [COORD_BITS-1:0] r;
        r = (v > {1'b0, COORD_MAX}) ? COORD_MAX : v[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic seg_t first_seg(input logic [DIM_BITS-1:0] aw);
        seg_t s;
        s.x = COORD_BITS'(1);
        s.y = COORD_BITS'(1);
        s.w = (aw >= DIM_BITS'(2)) ? sat_coord(aw - DIM_BITS'(2)) : '0;
        return s;
    endfunction

endpackage

@@ src/skyline_rect_allocator_top.sv @@
// allocate: the time from accept to result is set by the fit scan (one chain step per cycle)
//   and the rebuild pass (one segment a cycle)
// clear and store-full requests skip the scan; one item in flight, the next accepted
//   while a finished result still waits in the output register
// reset (synchronous, active low): atlas 512 x 512, one segment (1, 1, 510), area zero
module skyline_rect_allocator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [sra_pkg::DIM_BITS-1:0]   cfg_wr_data,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [sra_pkg::COORD_BITS-1:0] s_req_width,
    input  logic [sra_pkg::COORD_BITS-1:0] s_req_height,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_placed,
    output logic [sra_pkg::COORD_BITS-1:0] m_pos_x,
    output logic [sra_pkg::COORD_BITS-1:0] m_pos_y,
    output logic [sra_pkg::AREA_BITS-1:0]  m_used_area
);
    import sra_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // candidate seen at the end of the chain
    typedef struct packed {
        logic [IDX_BITS-1:0]   idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
    } cand_t;

    logic [2:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [COORD_BITS-1:0] req_w_reg, req_w_next, req_h_reg, req_h_next;
    logic [DIM_BITS-1:0]   atlas_w_reg, atlas_h_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   c_orig_reg, c_orig_next;
    logic [CNT_BITS-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                  ins_done_reg, ins_done_next;
    logic                  trim_reg, trim_next;
    logic [DIM_BITS-1:0]   end_reg, end_next;
    seg_t                  new_seg_reg, new_seg_next;
    logic [IDX_BITS-1:0]   b_reg, b_next;
    logic                  have_reg, have_next;
    logic [DIM_BITS-1:0]   top_reg, top_next;
    cand_t                 first_reg, first_next;
    logic                  nz_have_reg, nz_have_next;
    cand_t                 nz_reg, nz_next;
    logic                  pend_v_reg, pend_v_next;
    seg_t                  pend_reg, pend_next;
    logic [AREA_BITS-1:0]  area_reg, area_next;
    logic                  res_placed_reg, res_placed_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_placed_reg, m_placed_next;
    logic [COORD_BITS-1:0] m_pos_x_reg, m_pos_x_next, m_pos_y_reg, m_pos_y_next;
    logic [AREA_BITS-1:0]  m_area_reg, m_area_next;

    cell_ctl_t             ctl;
    seg_t                  seg_q     [MAX_SEGMENTS];
    probe_t                probe_out [MAX_SEGMENTS];
    probe_t                tail_probe;
    cand_t                 cand, sel;
    logic                  cand_ok;
    logic [DIM_BITS-1:0]   cand_top;
    logic [PROD_BITS-1:0]  area_prod;
    logic [SUM_BITS-1:0]   area_sum;
    logic                  accept;

    // ------------------------------------------------------------------
    // chain of segment cells; probes walk up, the queue drains toward cell 0
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
        seg_t   seg_up;
        probe_t probe_in;
        if (gi == MAX_SEGMENTS - 1) begin : g_last
            assign seg_up = '0;
        end else begin : g_mid
            assign seg_up = seg_q[gi+1];
        end
        if (gi == 0) begin : g_first
            assign probe_in = '0;
        end else begin : g_rest
            assign probe_in = probe_out[gi-1];
        end
        sra_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .cell_idx  (IDX_BITS'(gi)),
            .seg_up    (seg_up),
            .probe_in  (probe_in),
            .seg_q     (seg_q[gi]),
            .probe_out (probe_out[gi])
        );
    end

    assign tail_probe = probe_out[MAX_SEGMENTS-1];
    assign cand_ok    = tail_probe.active && tail_probe.ok && tail_probe.left == '0;
    assign cand.idx   = tail_probe.idx;
    assign cand.x     = tail_probe.x;
    assign cand.y     = tail_probe.y;
    assign cand.w     = tail_probe.w;
    assign cand_top   = {1'b0, tail_probe.y} + {1'b0, req_h_reg};

    // candidates leave the chain highest index first: the lowest index with the
    // best top is the first one, the narrowest nonzero width keeps its lowest index
    assign sel = (first_reg.w == '0) ? first_reg : nz_reg;

    assign area_prod = req_w_reg * req_h_reg;
    assign area_sum  = SUM_BITS'(area_reg) + SUM_BITS'(area_prod);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign m_valid     = m_valid_reg;
    assign m_placed    = m_placed_reg;
    assign m_pos_x     = m_pos_x_reg;
    assign m_pos_y     = m_pos_y_reg;
    assign m_used_area = m_area_reg;

    always_comb begin
        seg_t                  item;
        logic                  item_v;
        logic [DIM_BITS-1:0]   shrink;
        logic [DIM_BITS-1:0]   wsum;

        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        req_w_next      = req_w_reg;
        req_h_next      = req_h_reg;
        count_next      = count_reg;
        c_orig_next     = c_orig_reg;
        rd_cnt_next     = rd_cnt_reg;
        ins_done_next   = ins_done_reg;
        trim_next       = trim_reg;
        end_next        = end_reg;
        new_seg_next    = new_seg_reg;
        b_next          = b_reg;
        have_next       = have_reg;
        top_next        = top_reg;
        first_next      = first_reg;
        nz_have_next    = nz_have_reg;
        nz_next         = nz_reg;
        pend_v_next     = pend_v_reg;
        pend_next       = pend_reg;
        area_next       = area_reg;
        res_placed_next = res_placed_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_placed_next   = m_placed_reg;
        m_pos_x_next    = m_pos_x_reg;
        m_pos_y_next    = m_pos_y_reg;
        m_area_next     = m_area_reg;

        item   = '0;
        item_v = 1'b0;
        shrink = '0;
        wsum   = '0;

        ctl              = '0;
        ctl.occ          = count_reg;
        ctl.req_w        = req_w_reg;
        ctl.req_h        = req_h_reg;
        ctl.atlas_w      = atlas_w_reg;
        ctl.atlas_h      = atlas_h_reg;
        ctl.clear_seg    = first_seg(atlas_w_reg);
        ctl.push_seg     = pend_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_placed_next = 1'b0;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    if (s_req_type == REQ_CLEAR) begin
                        // back to a single segment across the inner width
                        ctl.load_clear = 1'b1;
                        count_next     = CNT_BITS'(1);
                        area_next      = '0;
                        state_next     = ST_OUT;
                    end else if (count_reg == CNT_BITS'(MAX_SEGMENTS)) begin
                        // store full, nothing changes
                        state_next = ST_OUT;
                    end else begin
                        req_w_next = s_req_width;
                        req_h_next = s_req_height;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                // every cell launches a probe for its own segment
                ctl.search_start = 1'b1;
                have_next        = 1'b0;
                nz_have_next     = 1'b0;
                scan_cnt_next    = '0;
                state_next       = ST_SCAN;
            end
            ST_SCAN: begin
                ctl.search_step = 1'b1;
                if (cand_ok) begin
                    if (!have_reg || cand_top < top_reg) begin
                        have_next    = 1'b1;
                        top_next     = cand_top;
                        first_next   = cand;
                        nz_have_next = (cand.w != '0);
                        nz_next      = cand;
                    end else if (cand_top == top_reg) begin
                        first_next = cand;
                        if (cand.w != '0 && (!nz_have_reg || cand.w <= nz_reg.w)) begin
                            nz_have_next = 1'b1;
                            nz_next      = cand;
                        end
                    end
                end
                scan_cnt_next = scan_cnt_reg + CNT_BITS'(1);
                if (scan_cnt_reg == CNT_BITS'(MAX_SEGMENTS - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!have_reg) begin
                    state_next = ST_OUT;
                end else begin
                    b_next          = sel.idx;
                    new_seg_next.x  = sel.x;
                    new_seg_next.y  = sat_coord({1'b0, sel.y} + {1'b0, req_h_reg});
                    new_seg_next.w  = req_w_reg;
                    end_next        = {1'b0, sel.x} + {1'b0, req_w_reg};
                    res_x_next      = sel.x;
                    res_y_next      = sel.y;
                    c_orig_next     = count_reg;
                    rd_cnt_next     = '0;
                    ins_done_next   = 1'b0;
                    trim_next       = 1'b0;
                    pend_v_next     = 1'b0;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // rebuild pass: old list streams out of cell 0, new list in at the tail
                if (!ins_done_reg && rd_cnt_reg == CNT_BITS'(b_reg)) begin
                    item          = new_seg_reg;
                    item_v        = 1'b1;
                    ins_done_next = 1'b1;
                    trim_next     = 1'b1;
                end else if (rd_cnt_reg < c_orig_reg) begin
                    ctl.pop     = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CNT_BITS'(1);
                    item        = seg_q[0];
                    item_v      = 1'b1;
                    if (trim_reg) begin
                        // segments under the new rectangle are cut back or dropped
                        trim_next = 1'b0;
                        if ({1'b0, seg_q[0].x} < end_reg) begin
                            shrink = end_reg - {1'b0, seg_q[0].x};
                            if ({1'b0, seg_q[0].w} <= shrink) begin
                                item_v    = 1'b0;
                                trim_next = 1'b1;
                            end else begin
                                item.x = sat_coord(end_reg);
                                item.w = seg_q[0].w - shrink[COORD_BITS-1:0];
                            end
                        end
                    end
                end else begin
                    state_next = ST_FINISH;
                end
                if (item_v) begin
                    // merge runs of equal height on the way
                    if (pend_v_reg && pend_reg.y == item.y) begin
                        wsum        = {1'b0, pend_reg.w} + {1'b0, item.w};
                        pend_next.w = sat_coord(wsum);
                    end else begin
                        ctl.push    = pend_v_reg;
                        pend_next   = item;
                        pend_v_next = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                ctl.push        = pend_v_reg;
                pend_v_next     = 1'b0;
                area_next       = (area_sum > SUM_BITS'(AREA_MAX)) ?
                                  AREA_MAX : area_sum[AREA_BITS-1:0];
                res_placed_next = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_placed_next = res_placed_reg;
                    m_pos_x_next  = res_x_reg;
                    m_pos_y_next  = res_y_reg;
                    m_area_next   = area_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.pop && !ctl.push) begin
            count_next = count_reg - CNT_BITS'(1);
        end else if (ctl.push && !ctl.pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= CNT_BITS'(1);
            area_reg    <= '0;
            m_valid_reg <= 1'b0;
            atlas_w_reg <= ATLAS_RESET;
            atlas_h_reg <= ATLAS_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            area_reg    <= area_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ATLAS_W: atlas_w_reg <= cfg_wr_data;
                    CFG_ATLAS_H: atlas_h_reg <= cfg_wr_data;
                    default:     atlas_w_reg <= atlas_w_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        scan_cnt_reg   <= scan_cnt_next;
        req_w_reg      <= req_w_next;
        req_h_reg      <= req_h_next;
        c_orig_reg     <= c_orig_next;
        rd_cnt_reg     <= rd_cnt_next;
        ins_done_reg   <= ins_done_next;
        trim_reg       <= trim_next;
        end_reg        <= end_next;
        new_seg_reg    <= new_seg_next;
        b_reg          <= b_next;
        have_reg       <= have_next;
        top_reg        <= top_next;
        first_reg      <= first_next;
        nz_have_reg    <= nz_have_next;
        nz_reg         <= nz_next;
        pend_v_reg     <= pend_v_next;
        pend_reg       <= pend_next;
        res_placed_reg <= res_placed_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        m_placed_reg   <= m_placed_next;
        m_pos_x_reg    <= m_pos_x_next;
        m_pos_y_reg    <= m_pos_y_next;
        m_area_reg     <= m_area_next;
    end

endmodule

@@ src/sra_cell.sv @@
module sra_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sra_pkg::cell_ctl_t           ctl,
    input  logic [sra_pkg::IDX_BITS-1:0] cell_idx,
    input  sra_pkg::seg_t                seg_up,
    input  sra_pkg::probe_t              probe_in,
    output sra_pkg::seg_t                seg_q,
    output sra_pkg::probe_t              probe_out
);
    import sra_pkg::*;

    seg_t                seg_reg, seg_next;
    probe_t              probe_reg, probe_next, probe_init;
    logic [CNT_BITS-1:0] my_pos;
    logic                seg_valid;
    logic [COORD_BITS-1:0] max_y;
    logic [DIM_BITS:0]   x_end, y_end;

    assign my_pos    = CNT_BITS'(cell_idx);
    assign seg_valid = my_pos < ctl.occ;
    assign seg_q     = seg_reg;

    // right edge check for a probe born here
    assign x_end = {2'b00, seg_reg.x} + {2'b00, ctl.req_w} + (DIM_BITS+1)'(1);
    assign max_y = (seg_reg.y > probe_reg.y) ? seg_reg.y : probe_reg.y;
    assign y_end = {2'b00, max_y} + {2'b00, ctl.req_h} + (DIM_BITS+1)'(1);

    always_comb begin
        probe_init.active = seg_valid;
        probe_init.ok     = seg_valid && !(x_end > {1'b0, ctl.atlas_w});
        probe_init.left   = ctl.req_w;
        probe_init.y      = seg_reg.y;
        probe_init.idx    = cell_idx;
        probe_init.x      = seg_reg.x;
        probe_init.w      = seg_reg.w;
    end

    // probe passing over this segment
    always_comb begin
        probe_out = probe_reg;
        if (probe_reg.active && probe_reg.ok && probe_reg.left != '0) begin
            if (!seg_valid) begin
                probe_out.ok = 1'b0;
            end else begin
                probe_out.y = max_y;
                if (y_end > {1'b0, ctl.atlas_h}) begin
                    probe_out.ok = 1'b0;
                end
                probe_out.left = (probe_reg.left > seg_reg.w) ?
                                 probe_reg.left - seg_reg.w : '0;
            end
        end
    end

    always_comb begin
        probe_next = probe_reg;
        if (ctl.search_start) begin
            probe_next = probe_init;
        end else if (ctl.search_step) begin
            probe_next = probe_in;
        end
    end

    // shift-register queue: pop moves toward cell 0, push lands at the tail
    always_comb begin
        seg_next = seg_reg;
        if (ctl.load_clear) begin
            if (cell_idx == '0) begin
                seg_next = ctl.clear_seg;
            end
        end else if (ctl.pop) begin
            seg_next = seg_up;
            if (ctl.push && my_pos == ctl.occ - CNT_BITS'(1)) begin
                seg_next = ctl.push_seg;
            end
        end else if (ctl.push && my_pos == ctl.occ) begin
            seg_next = ctl.push_seg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg   <= (cell_idx == '0) ? first_seg(ATLAS_RESET) : '0;
            probe_reg <= '0;
        end else begin
            seg_reg   <= seg_next;
            probe_reg <= probe_next;
        end
    end

endmodule

@@ src/sra_checker.sv @@
`include "assert_macros.svh"

module sra_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic                           cfg_index,
    input logic [sra_pkg::DIM_BITS-1:0]   cfg_wr_data,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_req_type,
    input logic [sra_pkg::COORD_BITS-1:0] s_req_width,
    input logic [sra_pkg::COORD_BITS-1:0] s_req_height,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_placed,
    input logic [sra_pkg::COORD_BITS-1:0] m_pos_x,
    input logic [sra_pkg::COORD_BITS-1:0] m_pos_y,
    input logic [sra_pkg::AREA_BITS-1:0]  m_used_area
);
    import sra_pkg::*;

    // stalled result holds
    `SRA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_placed) && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_used_area))

    // a failed or clear item reports the origin
    `SRA_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_valid && !m_placed, m_pos_x == '0 && m_pos_y == '0)

    // one item at a time
    `SRA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind skyline_rect_allocator_top sra_checker u_sra_checker (.*);
